/* rtl/core/u8d_pkg.sv */
// shared types and constants of the utf-8 decoder
`timescale 1ns / 1ps

package u8d_pkg;

   // counter width and saturation value
   localparam int COUNT_BITS = 24;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   // code point width and limits
   localparam int CP_BITS = 21;
   localparam logic [CP_BITS-1:0] CP_MIN2      = 21'h000080;
   localparam logic [CP_BITS-1:0] CP_MIN3      = 21'h000800;
   localparam logic [CP_BITS-1:0] CP_MIN4      = 21'h010000;
   localparam logic [CP_BITS-1:0] CP_SURR_LO   = 21'h00D800;
   localparam logic [CP_BITS-1:0] CP_SURR_HI   = 21'h00DFFF;
   localparam logic [CP_BITS-1:0] CP_MAX       = 21'h10FFFF;

   // byte classes
   localparam logic [2:0] CLS_ASCII = 3'd0;
   localparam logic [2:0] CLS_LEAD2 = 3'd1;
   localparam logic [2:0] CLS_LEAD3 = 3'd2;
   localparam logic [2:0] CLS_LEAD4 = 3'd3;
   localparam logic [2:0] CLS_CONT  = 3'd4;
   localparam logic [2:0] CLS_BAD   = 3'd5;

   // sequence lengths
   localparam logic [2:0] LEN_1 = 3'd1;
   localparam logic [2:0] LEN_2 = 3'd2;
   localparam logic [2:0] LEN_3 = 3'd3;
   localparam logic [2:0] LEN_4 = 3'd4;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ILLEGAL   = 2'd1;
   localparam logic [1:0] STATUS_EXHAUSTED = 2'd2;

   // classified byte as held in the queue
   typedef struct packed {
      logic [2:0] cls;
      logic [6:0] bits;
      logic       last;
   } item_type;

endpackage

/* rtl/core/utf8_to_codepoint_decoder_top.sv */
// utf-8 decoder top: classifier, queue and decoding back end
// bytes are queued, then decoded into the output register; throughput: one byte per cycle
// unless rsp_stall holds a result, set by the single-step back end and two-entry queue
// req_stall rises only when the queue holds two bytes; results wait in an output register
// reset: synchronous, active high; clears stream state and sets capacity to all ones
`timescale 1ns / 1ps

module utf8_to_codepoint_decoder_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [u8d_pkg::COUNT_BITS-1:0]  csr_write_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_last_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_char_valid,
   output logic [u8d_pkg::CP_BITS-1:0]     rsp_codepoint,
   output logic                            rsp_stream_done,
   output logic [1:0]                      rsp_status,
   output logic [u8d_pkg::COUNT_BITS-1:0]  rsp_bytes_consumed,
   output logic [u8d_pkg::COUNT_BITS-1:0]  rsp_chars_written
);

   u8d_pkg::item_type in_item;
   u8d_pkg::item_type head_item;
   logic              q_full;
   logic              head_valid;
   logic              pop;

   assign req_stall = q_full;

   // byte classification
   u8d_front u_front (
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .item      (in_item)
   );

   // decoupling queue
   u8d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid && !q_full),
      .push_item  (in_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // sequence decoding
   u8d_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .head_valid         (head_valid),
      .head_item          (head_item),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_char_valid     (rsp_char_valid),
      .rsp_codepoint      (rsp_codepoint),
      .rsp_stream_done    (rsp_stream_done),
      .rsp_status         (rsp_status),
      .rsp_bytes_consumed (rsp_bytes_consumed),
      .rsp_chars_written  (rsp_chars_written)
   );

endmodule

/* rtl/core/u8d_front.sv */
// front end: classifies each incoming byte and strips its marker bits
`timescale 1ns / 1ps

module u8d_front (
   input  logic [7:0]        data_byte,
   input  logic              last_byte,
   output u8d_pkg::item_type item
);

   // lead and continuation byte decode
   always_comb begin
      item.last = last_byte;
      item.bits = 7'd0;
      if (data_byte[7] == 1'b0) begin
         item.cls  = u8d_pkg::CLS_ASCII;
         item.bits = data_byte[6:0];
      end else if (data_byte[7:6] == 2'b10) begin
         item.cls  = u8d_pkg::CLS_CONT;
         item.bits = {1'b0, data_byte[5:0]};
      end else if (data_byte[7:5] == 3'b110) begin
         item.cls  = u8d_pkg::CLS_LEAD2;
         item.bits = {2'b00, data_byte[4:0]};
      end else if (data_byte[7:4] == 4'b1110) begin
         item.cls  = u8d_pkg::CLS_LEAD3;
         item.bits = {3'b000, data_byte[3:0]};
      end else if (data_byte[7:3] == 5'b11110) begin
         item.cls  = u8d_pkg::CLS_LEAD4;
         item.bits = {4'b0000, data_byte[2:0]};
      end else begin
         item.cls  = u8d_pkg::CLS_BAD;
      end
   end

endmodule

/* rtl/core/u8d_queue.sv */
// two-entry queue between the classifier and the decoder
`timescale 1ns / 1ps

module u8d_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  u8d_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output u8d_pkg::item_type head_item
);

   u8d_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_item  = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
   a_no_over: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");
   a_no_under: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("pop from empty queue");

endmodule

/* rtl/core/u8d_back.sv */
// back end: sequence assembly, validation, counters and result register
`timescale 1ns / 1ps

module u8d_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [u8d_pkg::COUNT_BITS-1:0]  csr_write_data,
   input  logic                            head_valid,
   input  u8d_pkg::item_type               head_item,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_char_valid,
   output logic [u8d_pkg::CP_BITS-1:0]     rsp_codepoint,
   output logic                            rsp_stream_done,
   output logic [1:0]                      rsp_status,
   output logic [u8d_pkg::COUNT_BITS-1:0]  rsp_bytes_consumed,
   output logic [u8d_pkg::COUNT_BITS-1:0]  rsp_chars_written
);

   localparam int CB = u8d_pkg::COUNT_BITS;
   localparam int CW = u8d_pkg::CP_BITS;

   // capacity register
   logic [CB-1:0] capacity_ff;

   // decoder state
   logic [CW-1:0] partial_ff, partial_in;
   logic [1:0]    pending_ff, pending_in;
   logic [2:0]    seq_len_ff, seq_len_in;
   logic [CB-1:0] byte_cnt_ff, byte_cnt_in;
   logic [CB-1:0] char_cnt_ff, char_cnt_in;
   logic          stopped_ff, stopped_in;
   logic          err_ff, err_in;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          char_valid_ff, char_valid_in;
   logic [CW-1:0] cp_ff, cp_in;
   logic          done_ff, done_in;
   logic [1:0]    status_ff, status_in;
   logic [CB-1:0] bytes_out_ff, bytes_out_in;
   logic [CB-1:0] chars_out_ff, chars_out_in;

   logic          emit;
   logic [CW-1:0] joined;
   logic [1:0]    pend_dec;
   logic [2:0]    done_len;
   logic [CB:0]   byte_sum;
   logic          bad_range;

   // one queue entry per cycle while the result register can take a result
   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   // continuation merge and range checks of a finished sequence
   always_comb begin
      joined   = {partial_ff[CW-7:0], head_item.bits[5:0]};
      pend_dec = pending_ff - 2'd1;
      // length of a sequence that completes on this byte
      done_len = (pending_ff == 2'd0) ? u8d_pkg::LEN_1 : seq_len_ff;
      byte_sum = {1'b0, byte_cnt_ff} + {{(CB-2){1'b0}}, done_len};
      unique case (seq_len_ff)
         u8d_pkg::LEN_2: bad_range = (joined < u8d_pkg::CP_MIN2);
         u8d_pkg::LEN_3: bad_range = (joined < u8d_pkg::CP_MIN3) ||
            ((joined >= u8d_pkg::CP_SURR_LO) && (joined <= u8d_pkg::CP_SURR_HI));
         u8d_pkg::LEN_4: bad_range = (joined < u8d_pkg::CP_MIN4) ||
            (joined > u8d_pkg::CP_MAX);
         default:        bad_range = 1'b0;
      endcase
   end

   // next state and result
   always_comb begin
      partial_in   = partial_ff;
      pending_in   = pending_ff;
      seq_len_in   = seq_len_ff;
      byte_cnt_in  = byte_cnt_ff;
      char_cnt_in  = char_cnt_ff;
      stopped_in   = stopped_ff;
      err_in       = err_ff;
      emit          = 1'b0;
      char_valid_in = 1'b0;
      cp_in         = '0;
      done_in       = 1'b0;
      status_in     = u8d_pkg::STATUS_OK;
      bytes_out_in  = byte_cnt_ff;
      chars_out_in  = char_cnt_ff;

      if (stopped_ff) begin
         // dropping bytes until the end of the stream
         if (head_item.last) begin
            emit      = !err_ff;
            done_in   = 1'b1;
            status_in = u8d_pkg::STATUS_EXHAUSTED;
         end
      end else if (pending_ff == 2'd0) begin
         if (char_cnt_ff >= capacity_ff) begin
            // capacity reached before a new sequence
            if (head_item.last) begin
               emit      = 1'b1;
               done_in   = 1'b1;
               status_in = u8d_pkg::STATUS_EXHAUSTED;
            end else begin
               stopped_in = 1'b1;
            end
         end else begin
            case (head_item.cls)
               u8d_pkg::CLS_ASCII: begin
                  emit          = 1'b1;
                  char_valid_in = 1'b1;
                  cp_in         = {{(CW-7){1'b0}}, head_item.bits};
                  seq_len_in    = u8d_pkg::LEN_1;
               end
               u8d_pkg::CLS_LEAD2, u8d_pkg::CLS_LEAD3, u8d_pkg::CLS_LEAD4: begin
                  partial_in = {{(CW-7){1'b0}}, head_item.bits};
                  case (head_item.cls)
                     u8d_pkg::CLS_LEAD2: begin
                        seq_len_in = u8d_pkg::LEN_2;
                        pending_in = 2'd1;
                     end
                     u8d_pkg::CLS_LEAD3: begin
                        seq_len_in = u8d_pkg::LEN_3;
                        pending_in = 2'd2;
                     end
                     default: begin
                        seq_len_in = u8d_pkg::LEN_4;
                        pending_in = 2'd3;
                     end
                  endcase
                  if (head_item.last) begin
                     emit      = 1'b1;
                     done_in   = 1'b1;
                     status_in = u8d_pkg::STATUS_ILLEGAL;
                  end
               end
               default: begin
                  emit      = 1'b1;
                  done_in   = 1'b1;
                  status_in = u8d_pkg::STATUS_ILLEGAL;
               end
            endcase
         end
      end else begin
         // continuation byte expected
         if (head_item.cls != u8d_pkg::CLS_CONT) begin
            emit      = 1'b1;
            done_in   = 1'b1;
            status_in = u8d_pkg::STATUS_ILLEGAL;
         end else if (pend_dec != 2'd0) begin
            partial_in = joined;
            pending_in = pend_dec;
            if (head_item.last) begin
               emit      = 1'b1;
               done_in   = 1'b1;
               status_in = u8d_pkg::STATUS_ILLEGAL;
            end
         end else if (bad_range) begin
            emit      = 1'b1;
            done_in   = 1'b1;
            status_in = u8d_pkg::STATUS_ILLEGAL;
         end else begin
            emit          = 1'b1;
            char_valid_in = 1'b1;
            cp_in         = joined;
         end
      end

      // character completed: update counters, result carries new counts
      if (char_valid_in) begin
         byte_cnt_in  = byte_sum[CB] ? u8d_pkg::CNT_MAX : byte_sum[CB-1:0];
         char_cnt_in  = (char_cnt_ff != u8d_pkg::CNT_MAX) ?
                        char_cnt_ff + {{(CB-1){1'b0}}, 1'b1} : char_cnt_ff;
         bytes_out_in = byte_cnt_in;
         chars_out_in = char_cnt_in;
         done_in      = head_item.last;
         pending_in   = 2'd0;
         seq_len_in   = 3'd0;
         partial_in   = '0;
      end else if (status_in == u8d_pkg::STATUS_ILLEGAL) begin
         stopped_in = 1'b1;
         err_in     = 1'b1;
         pending_in = 2'd0;
         seq_len_in = 3'd0;
         partial_in = '0;
      end

      // end of stream clears the stream state and counters
      if (head_item.last) begin
         partial_in  = '0;
         pending_in  = 2'd0;
         seq_len_in  = 3'd0;
         byte_cnt_in = '0;
         char_cnt_in = '0;
         stopped_in  = 1'b0;
         err_in      = 1'b0;
      end
   end

   // result valid
   always_comb begin
      if (pop) begin
         rsp_valid_in = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= u8d_pkg::CNT_MAX;
         partial_ff   <= '0;
         pending_ff   <= 2'd0;
         seq_len_ff   <= 3'd0;
         byte_cnt_ff  <= '0;
         char_cnt_ff  <= '0;
         stopped_ff   <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            capacity_ff <= csr_write_data;
         end
         if (pop) begin
            partial_ff  <= partial_in;
            pending_ff  <= pending_in;
            seq_len_ff  <= seq_len_in;
            byte_cnt_ff <= byte_cnt_in;
            char_cnt_ff <= char_cnt_in;
            stopped_ff  <= stopped_in;
            err_ff      <= err_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop && emit) begin
         char_valid_ff <= char_valid_in;
         cp_ff         <= cp_in;
         done_ff       <= done_in;
         status_ff     <= status_in;
         bytes_out_ff  <= bytes_out_in;
         chars_out_ff  <= chars_out_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_char_valid     = char_valid_ff;
   assign rsp_codepoint      = cp_ff;
   assign rsp_stream_done    = done_ff;
   assign rsp_status         = status_ff;
   assign rsp_bytes_consumed = bytes_out_ff;
   assign rsp_chars_written  = chars_out_ff;

   // checks
   a_stop_idle: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> (pending_ff == 2'd0)) else $error("stopped mid sequence");
   a_err_stop: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> stopped_ff) else $error("error without stop");
   a_pend_len: assert property (@(posedge clock) disable iff (reset)
      (pending_ff != 2'd0) |-> (seq_len_ff > {1'b0, pending_ff}))
      else $error("pending exceeds sequence length");
   a_char_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && char_valid_ff) |-> (status_ff == u8d_pkg::STATUS_OK))
      else $error("character with error status");

endmodule
